/* design/sse_pkg.sv */
// shared types, constants and coding functions for the s/pdif subframe encoder
package sse_pkg;

   // stereo frames in one channel-status block
   localparam int FRAMES_IN_BLOCK = 192;
   localparam int SUBFRAMES_IN_BLOCK = 2 * FRAMES_IN_BLOCK;
   localparam int POS_W = $clog2(SUBFRAMES_IN_BLOCK);
   localparam logic [POS_W-1:0] LAST_POSITION = POS_W'(SUBFRAMES_IN_BLOCK - 1);

   localparam int SAMPLE_W = 16;
   localparam int WORD_W = 32;

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // preamble words with zero sample and vucp bits
   localparam logic [WORD_W-1:0] PRE_B_WORD = 32'h3317_3333;
   localparam logic [WORD_W-1:0] PRE_M_WORD = 32'h331d_3333;
   localparam logic [WORD_W-1:0] PRE_W_WORD = 32'h331b_3333;

   typedef enum logic [1:0] {
      PRE_B,
      PRE_W,
      PRE_M
   } pre_type;

   // one classified subframe waiting for coding
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      pre_type             pre;
      logic                block_end;
   } entry_type;

   function automatic logic [WORD_W-1:0] pre_word(input pre_type pre);
      logic [WORD_W-1:0] w;
      unique case (pre)
         PRE_B:   w = PRE_B_WORD;
         PRE_W:   w = PRE_W_WORD;
         PRE_M:   w = PRE_M_WORD;
         default: w = PRE_M_WORD;
      endcase
      return w;
   endfunction

   // biphase-mark code of a byte, lsb first from bit 15, last half-cell 1
   function automatic logic [15:0] bmc_pattern(input logic [7:0] b);
      logic        level;
      logic [15:0] pat;
      level = ^b;
      pat = '0;
      for (int i = 0; i < 8; i++) begin
         if (i > 0) begin
            level = ~level;
         end
         pat[15 - 2*i] = level;
         level = level ^ b[i];
         pat[14 - 2*i] = level;
      end
      return pat;
   endfunction

endpackage

/* design/sse_front.sv */
// front end: accepts samples, tracks block position and classifies each subframe
module sse_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [sse_pkg::SAMPLE_W-1:0]      req_pcm_sample,
   input  logic                              q_full,
   output logic                              push,
   output sse_pkg::entry_type                push_entry
);

   logic [sse_pkg::POS_W-1:0] pos_ff;
   logic [sse_pkg::POS_W-1:0] pos_in;
   logic                      is_end;

   assign push = req_valid && !q_full;
   assign is_end = (pos_ff >= sse_pkg::LAST_POSITION);

   always_comb begin
      pos_in = pos_ff;
      if (push) begin
         pos_in = is_end ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_comb begin
      push_entry.sample = req_pcm_sample;
      push_entry.block_end = is_end;
      if (pos_ff == '0) begin
         push_entry.pre = sse_pkg::PRE_B;
      end else if (pos_ff[0]) begin
         push_entry.pre = sse_pkg::PRE_W;
      end else begin
         push_entry.pre = sse_pkg::PRE_M;
      end
   end

endmodule

/* design/sse_queue.sv */
// short fifo of classified subframes between front and back
module sse_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sse_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               q_valid,
   output sse_pkg::entry_type pop_entry
);

   sse_pkg::entry_type              mem_ff [sse_pkg::QUEUE_DEPTH];
   logic [sse_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [sse_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [sse_pkg::QCNT_W-1:0]      count_ff, count_in;

   localparam logic [sse_pkg::QPTR_W-1:0] PTR_LAST = sse_pkg::QPTR_W'(sse_pkg::QUEUE_DEPTH - 1);
   localparam logic [sse_pkg::QCNT_W-1:0] CNT_FULL = sse_pkg::QCNT_W'(sse_pkg::QUEUE_DEPTH);

   assign full = (count_ff == CNT_FULL);
   assign q_valid = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* design/sse_back.sv */
// back end: biphase-mark coding and the registered result word
module sse_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  sse_pkg::entry_type            pop_entry,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sse_pkg::WORD_W-1:0]    rsp_preamble_word,
   output logic [sse_pkg::WORD_W-1:0]    rsp_coded_word,
   output logic                          rsp_block_end
);

   logic                          valid_ff, valid_in;
   logic [sse_pkg::WORD_W-1:0]    pre_ff, pre_in;
   logic [sse_pkg::WORD_W-1:0]    coded_ff, coded_in;
   logic                          end_ff, end_in;
   logic [15:0]                   pat_lo, pat_hi;

   assign pop = q_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      pat_lo = sse_pkg::bmc_pattern(pop_entry.sample[7:0]);
      pat_hi = sse_pkg::bmc_pattern(pop_entry.sample[15:8]);
      coded_in = {pat_lo, 16'h0000} ^ {{16{pat_hi[15]}}, pat_hi};
      // clearing the top bit forces even parity
      coded_in[sse_pkg::WORD_W-1] = 1'b0;
      pre_in = sse_pkg::pre_word(pop_entry.pre);
      end_in = pop_entry.block_end;
      valid_in = pop || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pre_ff <= pre_in;
         coded_ff <= coded_in;
         end_ff <= end_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_preamble_word = pre_ff;
   assign rsp_coded_word = coded_ff;
   assign rsp_block_end = end_ff;

endmodule

/* design/spdif_subframe_encoder_core.sv */
// top level of the s/pdif subframe encoder
// one 16-bit pcm sample per input word, left and right alternating, gives one
// subframe as a preamble word (b at the start of a block, then w and m in turn)
// and a biphase-mark coded data word with even parity, plus a flag on the last
// subframe of each 384-subframe block. the front end keeps the block position
// and tags each sample, a two-entry queue holds tagged samples, and the back end
// codes both bytes through the pattern function and registers the result. the
// block takes one word per cycle and gives one result per cycle while no side
// stalls; a taken sample goes through a queue entry and the output register, and
// the queue takes two more words while the output is stalled
module spdif_subframe_encoder_core (
   input  logic                          clock,
   input  logic                          reset,
   // sample input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sse_pkg::SAMPLE_W-1:0]  req_pcm_sample,
   // subframe output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sse_pkg::WORD_W-1:0]    rsp_preamble_word,
   output logic [sse_pkg::WORD_W-1:0]    rsp_coded_word,
   output logic                          rsp_block_end
);

   logic               push;
   logic               pop;
   logic               q_full;
   logic               q_valid;
   sse_pkg::entry_type push_entry;
   sse_pkg::entry_type pop_entry;

   // stall only on a full queue, never on valid
   assign req_stall = q_full;

   // front: position counter and preamble / block-end tagging
   sse_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_pcm_sample (req_pcm_sample),
      .q_full         (q_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   // decoupling queue
   sse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .pop_entry  (pop_entry)
   );

   // back: coding and output register
   sse_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .pop_entry         (pop_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_preamble_word (rsp_preamble_word),
      .rsp_coded_word    (rsp_coded_word),
      .rsp_block_end     (rsp_block_end)
   );

endmodule

/* design/sse_checker.sv */
// port-level checks for the s/pdif subframe encoder
module sse_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [sse_pkg::WORD_W-1:0]    rsp_preamble_word,
   input logic [sse_pkg::WORD_W-1:0]    rsp_coded_word,
   input logic                          rsp_block_end
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_preamble_word)
         && $stable(rsp_coded_word) && $stable(rsp_block_end))
      else $error("stalled result word changed");

   // only the three preamble words appear
   a_pre_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_preamble_word == sse_pkg::PRE_B_WORD)
         || (rsp_preamble_word == sse_pkg::PRE_W_WORD)
         || (rsp_preamble_word == sse_pkg::PRE_M_WORD))
      else $error("unknown preamble word");

   // parity bit cleared and final half-cell high
   a_coded_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_coded_word[sse_pkg::WORD_W-1] && rsp_coded_word[0])
      else $error("coded word framing bits wrong");

   // the last subframe of a block is always a right channel one
   a_end_is_w: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_end |-> rsp_preamble_word == sse_pkg::PRE_W_WORD)
      else $error("block end on a non-w subframe");

   // queue is empty out of reset
   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_stall && !rsp_valid)
      else $error("not empty after reset");

endmodule

bind spdif_subframe_encoder_core sse_checker u_sse_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_preamble_word (rsp_preamble_word),
   .rsp_coded_word    (rsp_coded_word),
   .rsp_block_end     (rsp_block_end)
);

/* sim/spdif_subframe_encoder_core_test.sv */
// self-checking testbench for the s/pdif subframe encoder core
module spdif_subframe_encoder_core_test;

   // idle cycles without any accepted word before the run is called hung
   localparam int WATCHDOG_LIMIT = 2000;
   // long receiver hold-off that fills the internal queue and backs up the input
   localparam int BACKPRESSURE_CYCLES = 400;
   localparam int BACKPRESSURE_AFTER = 120;
   // cycles to wait once everything has come back
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_SAMPLES = 482;

   // what one subframe should look like on the rsp side
   typedef struct packed {
      logic [sse_pkg::WORD_W-1:0] preamble;
      logic [sse_pkg::WORD_W-1:0] coded;
      logic                       last_in_block;
   } subframe_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [sse_pkg::SAMPLE_W-1:0] req_pcm_sample = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [sse_pkg::WORD_W-1:0]   rsp_preamble_word;
   logic [sse_pkg::WORD_W-1:0]   rsp_coded_word;
   logic                         rsp_block_end;

   logic [sse_pkg::SAMPLE_W-1:0] samples_to_send[$];
   subframe_type                 subframes_due[$];

   // predictor copy of the block position
   logic [sse_pkg::POS_W-1:0]    block_pos = '0;

   // acceptance seen at the last rising edge, used by the falling-edge drivers
   logic                         sample_taken = 1'b0;
   logic                         subframe_taken = 1'b0;

   int                           samples_sent = 0;
   int                           subframes_seen = 0;
   int                           mismatch_count = 0;
   int                           idle_cycles = 0;

   spdif_subframe_encoder_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pcm_sample    (req_pcm_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_preamble_word (rsp_preamble_word),
      .rsp_coded_word    (rsp_coded_word),
      .rsp_block_end     (rsp_block_end)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // biphase-mark code of one byte: the line flips at every cell edge and
   // again mid-cell for a one; start level is chosen so the last half-cell is 1
   function automatic logic [15:0] biphase_code(input logic [7:0] value);
      logic        line;
      logic [15:0] code;
      line = ~(^value);
      code = '0;
      for (int i = 0; i < 8; i++) begin
         line = ~line;
         code[15 - 2*i] = line;
         line = line ^ value[i];
         code[14 - 2*i] = line;
      end
      return code;
   endfunction

   // expected subframe for one sample; advances the block position
   function automatic subframe_type encode_subframe(
      input logic [sse_pkg::SAMPLE_W-1:0] sample);
      subframe_type sf;
      logic [15:0]  hi_code;
      logic [31:0]  word;
      hi_code = biphase_code(sample[15:8]);
      // high-byte code sign-extended over the whole word, low-byte code on top
      word = {biphase_code(sample[7:0]), 16'h0000} ^ {{16{hi_code[15]}}, hi_code};
      // top bit cleared, parity comes out even
      sf.coded = {1'b0, word[30:0]};
      if (block_pos == '0) begin
         sf.preamble = sse_pkg::PRE_B_WORD;
      end else if (block_pos[0]) begin
         sf.preamble = sse_pkg::PRE_W_WORD;
      end else begin
         sf.preamble = sse_pkg::PRE_M_WORD;
      end
      // anything at or past the last slot closes the block
      sf.last_in_block = (block_pos >= sse_pkg::LAST_POSITION);
      if (sf.last_in_block) begin
         block_pos = '0;
      end else begin
         block_pos = block_pos + 1'b1;
      end
      return sf;
   endfunction

   // wait before the next word; every fourth stretch of 50 words runs back to back
   function automatic int draw_gap(input int words_done);
      if ((words_done / 50) % 4 == 1) begin
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   task automatic note_failure(input string what);
      if (mismatch_count < 10) begin
         $display("%0t: %s", $time, what);
      end
      mismatch_count++;
   endtask

   // a byte from the edges of its range
   function automatic logic [7:0] edge_byte();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hff;
         2:       return 8'h80;
         default: return 8'h01;
      endcase
   endfunction

   // stimulus, reset and the end of the run
   initial begin
      logic [sse_pkg::SAMPLE_W-1:0] directed[$];
      logic [sse_pkg::SAMPLE_W-1:0] s;
      // all-zero and all-one samples, single bytes at both ends, lone top and
      // bottom bits, high bytes of odd parity so the sign extension shows,
      // alternating patterns
      directed = '{16'h0000, 16'hffff, 16'h00ff, 16'hff00, 16'h0001, 16'h0080,
                   16'h0100, 16'h8000, 16'h7fff, 16'h8080, 16'h0180, 16'h8001,
                   16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0, 16'h1234, 16'hfe01};
      foreach (directed[i]) begin
         samples_to_send.push_back(directed[i]);
      end
      // random part long enough to cross a block boundary
      for (int i = 0; i < RANDOM_SAMPLES; i++) begin
         case ($urandom_range(0, 9))
            0:       s = {edge_byte(), edge_byte()};
            1:       s = sse_pkg::SAMPLE_W'(1) << $urandom_range(0, sse_pkg::SAMPLE_W - 1);
            2:       s = ~(sse_pkg::SAMPLE_W'(1) << $urandom_range(0, sse_pkg::SAMPLE_W - 1));
            default: s = sse_pkg::SAMPLE_W'($urandom);
         endcase
         samples_to_send.push_back(s);
      end

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // every sample handed over and every subframe back
      while (samples_to_send.size() != 0 || req_valid || subframes_due.size() != 0) begin
         @(posedge clock);
      end
      // no stray words after the last one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // input side: note accepted words and predict their subframes
   always @(posedge clock) begin
      sample_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         subframes_due.push_back(encode_subframe(req_pcm_sample));
      end
   end

   // sample driver: one word at a time with a random gap before each
   always @(negedge clock) begin : drive_samples
      int send_gap;
      if (!reset) begin
         if (req_valid && sample_taken) begin
            samples_sent++;
            send_gap = draw_gap(samples_sent);
         end
         if (req_valid && !sample_taken) begin
            // stalled: word stays as it is
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
            // junk on the bus while nothing is offered
            req_pcm_sample <= sse_pkg::SAMPLE_W'($urandom);
         end else if (samples_to_send.size() != 0) begin
            req_valid <= 1'b1;
            req_pcm_sample <= samples_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side: every accepted subframe against the oldest prediction
   always @(posedge clock) begin : check_subframes
      subframe_type want;
      subframe_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         subframes_seen++;
         if (subframes_due.size() == 0) begin
            note_failure($sformatf("subframe with nothing due: pre %h coded %h end %b",
                                   rsp_preamble_word, rsp_coded_word, rsp_block_end));
         end else begin
            want = subframes_due.pop_front();
            if (rsp_preamble_word !== want.preamble) begin
               note_failure($sformatf("subframe %0d preamble: expected %h got %h",
                                      subframes_seen, want.preamble, rsp_preamble_word));
            end
            if (rsp_coded_word !== want.coded) begin
               note_failure($sformatf("subframe %0d coded word: expected %h got %h",
                                      subframes_seen, want.coded, rsp_coded_word));
            end
            if (rsp_block_end !== want.last_in_block) begin
               note_failure($sformatf("subframe %0d block end: expected %b got %b",
                                      subframes_seen, want.last_in_block, rsp_block_end));
            end
         end
      end
   end

   // receiver stall: a random hold before each word, plus one long hold-off
   always @(negedge clock) begin : drive_stall
      int stall_left;
      int hold_left;
      bit hold_done;
      if (subframe_taken) begin
         stall_left = draw_gap(subframes_seen);
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && subframes_seen >= BACKPRESSURE_AFTER) begin
         // sender keeps going, so the queue fills and req_stall must rise
         hold_done = 1'b1;
         hold_left = BACKPRESSURE_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog: too long with no word moving on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

/* files.f */
design/sse_pkg.sv
design/sse_front.sv
design/sse_queue.sv
design/sse_back.sv
design/spdif_subframe_encoder_core.sv
design/sse_checker.sv
sim/spdif_subframe_encoder_core_test.sv
